// File: hw/rtl/ctb_pkg.sv
// Shared types and constants for the Cartesian tree builder.
package ctb_pkg;

  localparam int unsigned MaxNodesDef = 1024;
  localparam int unsigned IdW         = 11;
  localparam int unsigned PrioW       = 32;
  localparam int unsigned OpW         = 2;

  typedef enum logic [OpW-1:0] {
    OP_INSERT  = 2'd0,
    OP_QUERY   = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_I_CHK,
    ST_I_POP,
    ST_I_LOAD,
    ST_I_LINK,
    ST_I_FIX,
    ST_Q_OUT
  } state_e;

  // read address source for the link tables
  typedef enum logic [1:0] {
    TAB_IN,
    TAB_ID,
    TAB_TOP
  } tab_sel_e;

  typedef struct packed {
    logic     accept;
    tab_sel_e tab_sel;
    logic     clr_we;
    logic     pop;
    logic     load_top;
    logic     link_we;
    logic     fix_we;
    logic     out_load;
  } ctb_cmd_t;

  typedef struct packed {
    logic can_insert;
    logic pop_cond;
    logic clr_done;
    logic out_free;
  } ctb_sts_t;

endpackage

// File: hw/rtl/ctb_ctrl.sv
// Sequencer for insert, query and restart.
module ctb_ctrl import ctb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  op_e      in_op_i,
  output logic     in_ready_o,
  input  ctb_sts_t sts_i,
  output ctb_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (sts_i.clr_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_op_i)
            OP_INSERT:  state_d = ST_I_CHK;
            OP_QUERY:   state_d = ST_Q_OUT;
            OP_RESTART: state_d = ST_CLEAR;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_I_CHK:  state_d = sts_i.can_insert ? ST_I_POP : ST_IDLE;
      ST_I_POP:  state_d = sts_i.pop_cond ? ST_I_LOAD : ST_I_LINK;
      ST_I_LOAD: state_d = ST_I_POP;
      ST_I_LINK: state_d = ST_I_FIX;
      ST_I_FIX:  state_d = ST_IDLE;
      ST_Q_OUT:  if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.tab_sel  = TAB_ID;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_CLEAR:  cmd_o.clr_we = 1'b1;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.tab_sel = TAB_IN;
        cmd_o.accept  = in_valid_i;
      end
      ST_I_POP: begin
        cmd_o.tab_sel = TAB_TOP;
        cmd_o.pop     = sts_i.pop_cond;
      end
      ST_I_LOAD: cmd_o.load_top = 1'b1;
      ST_I_LINK: cmd_o.link_we  = 1'b1;
      ST_I_FIX:  cmd_o.fix_we   = 1'b1;
      ST_Q_OUT:  cmd_o.out_load = sts_i.out_free;
      default:   cmd_o.clr_we   = 1'b0;
    endcase
  end

endmodule

// File: hw/rtl/ctb_dpath.sv
// Link tables, valid bits, rightmost-path stack and the result register.
module ctb_dpath import ctb_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodesDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [PrioW-1:0] in_prio_i,
  input  logic [IdW-1:0]          in_id_i,
  input  ctb_cmd_t                cmd_i,
  output ctb_sts_t                sts_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [IdW-1:0]          out_parent_o,
  output logic [IdW-1:0]          out_left_o,
  output logic [IdW-1:0]          out_right_o,
  output logic [IdW-1:0]          out_root_o,
  output logic                    out_known_o
);

  localparam int unsigned AW  = $clog2(MAX_NODES + 1);
  localparam int unsigned SAW = $clog2(MAX_NODES);

  function automatic logic [AW-1:0] to_addr(input logic [IdW-1:0] id);
    logic [16:0] w;
    w = 17'(id);
    return w[AW-1:0];
  endfunction

  logic [IdW-1:0] par_mem [0:MAX_NODES];
  logic [IdW-1:0] lft_mem [0:MAX_NODES];
  logic [IdW-1:0] rgt_mem [0:MAX_NODES];
  logic           vld_mem [0:MAX_NODES];
  logic [IdW-1:0]   stk_id_mem [0:MAX_NODES-1];
  logic [PrioW-1:0] stk_pr_mem [0:MAX_NODES-1];

  logic [IdW-1:0]          id_q, top_id_q, root_q, r_q, r_d;
  logic signed [PrioW-1:0] prio_q, top_prio_q;
  logic [AW-1:0]           depth_q, clr_cnt_q;
  logic [IdW-1:0]          par_rd_q, lft_rd_q, rgt_rd_q, stk_id_rd_q;
  logic [PrioW-1:0]        stk_pr_rd_q;
  logic                    vld_rd_q, id_ok, depth_zero;
  logic [AW-1:0]           tab_raddr, vld_raddr;
  logic [SAW-1:0]          stk_raddr;
  logic [AW-1:0]           depth_m2;
  logic                    out_valid_q;
  logic [IdW-1:0]          o_par_q, o_lft_q, o_rgt_q, o_root_q;
  logic                    o_known_q;

  assign id_ok      = (id_q != '0) && (17'(id_q) <= 17'(MAX_NODES));
  assign depth_zero = (depth_q == '0);
  assign r_d        = depth_zero ? root_q : rgt_rd_q;
  assign depth_m2   = depth_q - AW'(2);
  assign stk_raddr  = depth_m2[SAW-1:0];

  always_comb begin
    case (cmd_i.tab_sel)
      TAB_IN:  tab_raddr = to_addr(in_id_i);
      TAB_TOP: tab_raddr = to_addr(top_id_q);
      default: tab_raddr = to_addr(id_q);
    endcase
  end
  assign vld_raddr = (cmd_i.tab_sel == TAB_IN) ? to_addr(in_id_i) : to_addr(id_q);

  assign sts_o.can_insert = id_ok && !vld_rd_q;
  assign sts_o.pop_cond   = !depth_zero && (top_prio_q > prio_q);
  assign sts_o.clr_done   = (clr_cnt_q == AW'(MAX_NODES));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // memories
  always_ff @(posedge clk_i) begin
    par_rd_q <= par_mem[tab_raddr];
    lft_rd_q <= lft_mem[tab_raddr];
    rgt_rd_q <= rgt_mem[tab_raddr];
    vld_rd_q <= vld_mem[vld_raddr];
    stk_id_rd_q <= stk_id_mem[stk_raddr];
    stk_pr_rd_q <= stk_pr_mem[stk_raddr];
    if (cmd_i.link_we) begin
      par_mem[to_addr(id_q)] <= depth_zero ? '0 : top_id_q;
    end else if (cmd_i.fix_we && (r_q != '0)) begin
      par_mem[to_addr(r_q)] <= id_q;
    end
    if (cmd_i.link_we) begin
      lft_mem[to_addr(id_q)] <= r_d;
    end
    if (cmd_i.link_we) begin
      rgt_mem[to_addr(id_q)] <= '0;
    end else if (cmd_i.fix_we && !depth_zero) begin
      rgt_mem[to_addr(top_id_q)] <= id_q;
    end
    if (cmd_i.clr_we) begin
      vld_mem[clr_cnt_q] <= 1'b0;
    end else if (cmd_i.link_we) begin
      vld_mem[to_addr(id_q)] <= 1'b1;
    end
    if (cmd_i.fix_we) begin
      stk_id_mem[depth_q[SAW-1:0]] <= id_q;
      stk_pr_mem[depth_q[SAW-1:0]] <= prio_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      id_q   <= in_id_i;
      prio_q <= in_prio_i;
    end
    if (cmd_i.link_we) r_q <= r_d;
    if (cmd_i.load_top) begin
      top_id_q   <= stk_id_rd_q;
      top_prio_q <= stk_pr_rd_q;
    end else if (cmd_i.fix_we) begin
      top_id_q   <= id_q;
      top_prio_q <= prio_q;
    end
    if (cmd_i.out_load) begin
      o_par_q   <= (id_ok && vld_rd_q) ? par_rd_q : '0;
      o_lft_q   <= (id_ok && vld_rd_q) ? lft_rd_q : '0;
      o_rgt_q   <= (id_ok && vld_rd_q) ? rgt_rd_q : '0;
      o_root_q  <= root_q;
      o_known_q <= id_ok && vld_rd_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      root_q      <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_we) begin
        depth_q   <= '0;
        root_q    <= '0;
        clr_cnt_q <= sts_o.clr_done ? '0 : clr_cnt_q + AW'(1);
      end else if (cmd_i.pop) begin
        depth_q <= depth_q - AW'(1);
      end else if (cmd_i.fix_we) begin
        depth_q <= depth_q + AW'(1);
        if (depth_zero) root_q <= id_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_parent_o = o_par_q;
  assign out_left_o   = o_lft_q;
  assign out_right_o  = o_rgt_q;
  assign out_root_o   = o_root_q;
  assign out_known_o  = o_known_q;

endmodule

// File: hw/rtl/cartesian_tree_builder.sv
// Top level of the Cartesian tree builder.
// Nodes arrive in increasing key order on the slave stream; tuser carries the
// operation (insert, query, restart), tdata the priority and the node id.
// A query gives one beat on the master stream with parent, left and right
// links, the current root, and a known flag in tuser. Insert, restart and the
// unused operation give no beat.
// An insert steps through I_CHK, I_POP, I_LINK and I_FIX, with an I_LOAD and
// a further I_POP for each node popped off the rightmost path; each node is
// popped at most once. The link tables, valid bits and path stack are
// single-port-write memories; I_LOAD takes up each registered stack read.
// One item is in work at a time; s_axis_tready is high only when idle.
// After reset, and after each restart, the valid bits are swept clear, one
// entry per cycle, over entries 0 to MAX_NODES with s_axis_tready low.
// A query result waits in the output register while m_axis_tready is low;
// a further query then stalls until it is taken.
module cartesian_tree_builder import ctb_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // priority_req[31:0], node_id[42:32], zero pad
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // parent_id, left_id, right_id, root_id, zero pad
  output logic        m_axis_tuser   // known
);

  ctb_cmd_t       cmd;
  ctb_sts_t       sts;
  logic [IdW-1:0] par, lft, rgt, root;

  ctb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (op_e'(s_axis_tuser)),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ctb_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_prio_i    (s_axis_tdata[31:0]),
    .in_id_i      (s_axis_tdata[42:32]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_parent_o (par),
    .out_left_o   (lft),
    .out_right_o  (rgt),
    .out_root_o   (root),
    .out_known_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0, root, rgt, lft, par};

endmodule
